@@ rtl/pol_pkg.sv @@
package pol_pkg;

   localparam int DATA_W     = 32;
   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 8;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_W    = 5;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_INS_POS   = 3'd2,
      ACT_REM_FRONT = 3'd3,
      ACT_REM_BACK  = 3'd4,
      ACT_REM_POS   = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   // Broadcast to every cell: what to do and where it starts.
   typedef struct packed {
      cell_op_type              op;
      logic [POSITION_W-1:0]    index;
      logic signed [DATA_W-1:0] data;
   } cell_cmd_type;

endpackage

@@ rtl/pol_cell.sv @@
module pol_cell
   import pol_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   output logic signed [DATA_W-1:0] slot_value
);

   localparam logic [POSITION_W-1:0] MY_INDEX = POSITION_W'(INDEX);

   logic signed [DATA_W-1:0] slot_ff;
   logic signed [DATA_W-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            if (MY_INDEX == cmd.index) begin
               slot_in = cmd.data;
            end else if (MY_INDEX > cmd.index) begin
               slot_in = left_value;
            end
         end
         OP_REMOVE: begin
            if (MY_INDEX >= cmd.index) begin
               slot_in = right_value;
            end
         end
         default: slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_value = slot_ff;

endmodule

@@ rtl/pol_ctrl.sv @@
module pol_ctrl
   import pol_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int OCC_W    = $clog2(CAPACITY + 1)
) (
   input  logic [ACTION_W-1:0]      action,
   input  logic signed [DATA_W-1:0] value,
   input  logic [POSITION_W-1:0]    position,
   input  logic [OCC_W-1:0]         occupancy,
   output cell_cmd_type             cmd,
   output status_type               status,
   output logic                     removing,
   output logic [OCC_W-1:0]         occupancy_next
);

   localparam logic [POSITION_W:0] CAP_EXT = (POSITION_W + 1)'(CAPACITY);

   logic [POSITION_W:0] occ_ext;
   logic [POSITION_W:0] pos_ext;
   logic                full;
   logic                empty;

   assign occ_ext = (POSITION_W + 1)'(occupancy);
   assign pos_ext = (POSITION_W + 1)'(position);
   assign full    = (occ_ext == CAP_EXT);
   assign empty   = (occupancy == '0);

   always_comb begin
      cmd.op         = OP_HOLD;
      cmd.index      = '0;
      cmd.data       = value;
      status         = ST_OK;
      removing       = 1'b0;
      occupancy_next = occupancy;
      unique case (action)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
            priority if (full) begin
               status = ST_FULL;
            end else if (action == ACT_INS_POS &&
                         (pos_ext == '0 || pos_ext > occ_ext + 1'b1)) begin
               status = ST_RANGE;
            end else begin
               cmd.op         = OP_INSERT;
               occupancy_next = occupancy + 1'b1;
               if (action == ACT_INS_BACK) begin
                  cmd.index = POSITION_W'(occupancy);
               end else if (action == ACT_INS_POS) begin
                  cmd.index = position - 1'b1;
               end
            end
         end
         ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_POS: begin
            priority if (empty) begin
               status = ST_EMPTY;
            end else if (action == ACT_REM_POS &&
                         (pos_ext == '0 || pos_ext > occ_ext)) begin
               status = ST_RANGE;
            end else begin
               cmd.op         = OP_REMOVE;
               removing       = 1'b1;
               occupancy_next = occupancy - 1'b1;
               if (action == ACT_REM_BACK) begin
                  cmd.index = POSITION_W'(occupancy - 1'b1);
               end else if (action == ACT_REM_POS) begin
                  cmd.index = position - 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

@@ rtl/positional_ordered_list.sv @@
// A result strobes on rsp_valid once its request has passed the request stage
// and the response registers. Throughput: one request per cycle; busy stays
// low, since every action is a single parallel shift across the slot cells.
// Reset: synchronous, clears the entry count and the pipeline valids; slot
// contents are left as they are and only slots below the count are read.
// Results cannot be stalled: each is on the rsp_ ports for one cycle only.
module positional_ordered_list
   import pol_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ACTION_W-1:0]          req_action,
   input  logic signed [DATA_W-1:0]     req_value,
   input  logic [POSITION_W-1:0]        req_position,
   output logic                         rsp_valid,
   output logic signed [DATA_W-1:0]     rsp_removed_value,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [ENTRY_W-1:0]           rsp_entry_count
);

   localparam int OCC_W = $clog2(CAPACITY + 1);

   // Request stage: the incoming request is registered before it reaches the
   // cells, which keeps the port-to-flop path short.
   logic                     req_valid_ff;
   logic [ACTION_W-1:0]      req_action_ff;
   logic signed [DATA_W-1:0] req_value_ff;
   logic [POSITION_W-1:0]    req_position_ff;

   // Entry count; the slots themselves live in the cells.
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   // Response registers.
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_removed_value_ff;
   status_type               rsp_status_ff;
   logic [ENTRY_W-1:0]       rsp_entry_count_ff;

   cell_cmd_type             ctrl_cmd;
   cell_cmd_type             cell_cmd;
   status_type               ctrl_status;
   logic                     ctrl_removing;
   logic signed [DATA_W-1:0] slot_q [CAPACITY];
   logic signed [DATA_W-1:0] hit_value [CAPACITY];
   logic signed [DATA_W-1:0] taken_value;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_action_ff   <= req_action;
      req_value_ff    <= req_value;
      req_position_ff <= req_position;
   end

   // Decode: turns the request and the current count into one command that
   // every cell sees, plus the status and the count after the action.
   pol_ctrl #(
      .CAPACITY (CAPACITY),
      .OCC_W    (OCC_W)
   ) u_ctrl (
      .action         (req_action_ff),
      .value          (req_value_ff),
      .position       (req_position_ff),
      .occupancy      (occ_ff),
      .cmd            (ctrl_cmd),
      .status         (ctrl_status),
      .removing       (ctrl_removing),
      .occupancy_next (occ_in)
   );

   // Cells only act when a request is really in the stage.
   always_comb begin
      cell_cmd = ctrl_cmd;
      if (!req_valid_ff) begin
         cell_cmd.op = OP_HOLD;
      end
   end

   // Row of slot cells. Insert pulls from the left neighbour, remove from the
   // right one; the ends take the cell's own value (never read past count).
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = slot_q[i];
      end else begin : g_mid_l
         assign left_value = slot_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = slot_q[i];
      end else begin : g_mid_r
         assign right_value = slot_q[i+1];
      end

      pol_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .left_value  (left_value),
         .right_value (right_value),
         .slot_value  (slot_q[i])
      );

      // One-hot pick of the value leaving the list.
      assign hit_value[i] = (cell_cmd.index == POSITION_W'(i)) ? slot_q[i] : '0;
   end

   always_comb begin
      taken_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         taken_value = taken_value | hit_value[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            occ_ff <= occ_in;
         end
      end
      rsp_removed_value_ff <= ctrl_removing ? taken_value : NONE_VALUE;
      rsp_status_ff        <= ctrl_status;
      rsp_entry_count_ff   <= ENTRY_W'(occ_in);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;

   // Count never goes past the row of cells.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(CAPACITY))
      else $error("entry count above capacity");

   // The count moves by at most one per request, and only with a request.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(req_valid_ff) |-> occ_ff == $past(occ_ff))
      else $error("entry count changed without a request");

   // A response follows each request stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid_ff)
      else $error("request stage lost its response");

   // A full report leaves the list at capacity; an error report carries NONE_VALUE.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |->
         rsp_entry_count_ff == ENTRY_W'(CAPACITY))
      else $error("full status with list not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_removed_value_ff == NONE_VALUE)
      else $error("error response carries a removed value");

endmodule

@@ tb/tb_positional_ordered_list.sv @@
`timescale 1ns / 1ps

module tb_positional_ordered_list;
   import pol_pkg::*;

   localparam int CAPACITY   = CAPACITY_DEFAULT;
   localparam int RAND_ITEMS = 1600;
   // The limit lies many times beyond the length of a correct run.
   localparam int CYCLE_LIMIT = 200000;
   // Cycles to drain after the last response, for anything stray.
   localparam int DRAIN_CYCLES = 8;

   // Codes 6 and 7 have no meaning; the list must leave itself alone.
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [DATA_W-1:0] removed;
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_W-1:0]       count;
   } list_outcome_type;

   // Tracks the list contents, predicts each response and compares against
   // what comes back on the rsp_ ports, oldest first.
   class list_scoreboard;
      logic signed [DATA_W-1:0] slots[CAPACITY];
      int                       occupancy;
      list_outcome_type         pending_outcomes[$];
      int                       mismatches;

      function new();
         occupancy  = 0;
         mismatches = 0;
      endfunction

      task flag_mismatch(input string what);
         $display("%0t list check: %s", $time, what);
         mismatches++;
      endtask

      function void insert_at(int idx, logic signed [DATA_W-1:0] val);
         for (int i = occupancy; i > idx; i--)
            slots[i] = slots[i-1];
         slots[idx] = val;
         occupancy++;
      endfunction

      function logic signed [DATA_W-1:0] take_at(int idx);
         logic signed [DATA_W-1:0] val;
         val = slots[idx];
         for (int i = idx; i + 1 < occupancy; i++)
            slots[i] = slots[i+1];
         occupancy--;
         return val;
      endfunction

      // Called once per accepted request.
      function void note_request(logic [ACTION_W-1:0] act,
                                 logic signed [DATA_W-1:0] val,
                                 logic [POSITION_W-1:0] pos);
         list_outcome_type o;
         o.removed = NONE_VALUE;
         o.status  = ST_OK;
         case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
               if (occupancy >= CAPACITY)
                  o.status = ST_FULL;
               else if (act == ACT_INS_FRONT)
                  insert_at(0, val);
               else if (act == ACT_INS_BACK)
                  insert_at(occupancy, val);
               else if (pos < 1 || pos > occupancy + 1)
                  o.status = ST_RANGE;
               else
                  insert_at(pos - 1, val);
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_POS: begin
               if (occupancy == 0)
                  o.status = ST_EMPTY;
               else if (act == ACT_REM_FRONT)
                  o.removed = take_at(0);
               else if (act == ACT_REM_BACK)
                  o.removed = take_at(occupancy - 1);
               else if (pos < 1 || pos > occupancy)
                  o.status = ST_RANGE;
               else
                  o.removed = take_at(pos - 1);
            end
            default: ;
         endcase
         o.count = occupancy[ENTRY_W-1:0];
         pending_outcomes.push_back(o);
      endfunction

      task check_response(input logic signed [DATA_W-1:0] removed,
                          input logic [STATUS_W-1:0] status,
                          input logic [ENTRY_W-1:0] count);
         list_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("response with no request outstanding");
         end else begin
            o = pending_outcomes.pop_front();
            if (removed !== o.removed)
               flag_mismatch($sformatf("removed_value %0d, want %0d", removed, o.removed));
            if (status !== o.status)
               flag_mismatch($sformatf("status %0d, want %0d", status, o.status));
            if (count !== o.count)
               flag_mismatch($sformatf("entry_count %0d, want %0d", count, o.count));
         end
      endtask

      function int outstanding();
         return pending_outcomes.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [ACTION_W-1:0]      req_action;
   logic signed [DATA_W-1:0] req_value;
   logic [POSITION_W-1:0]    req_position;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [ENTRY_W-1:0]       rsp_entry_count;

   list_scoreboard sb = new();
   int             cycle_count = 0;
   bit             allow_gaps;

   always #6 clock = ~clock;

   positional_ordered_list #(
      .CAPACITY(CAPACITY)
   ) DUT (
      clock,
      reset,
      start,
      busy,
      req_action,
      req_value,
      req_position,
      rsp_valid,
      rsp_removed_value,
      rsp_status,
      rsp_entry_count
   );

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Responses cannot be held off, so every strobe is taken as it comes.
   // Sampling at the edge sees the values of the cycle that edge closes.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_removed_value, rsp_status, rsp_entry_count);
   end

   // Drive one request and hold it until accepted (start high, busy low at
   // an edge). Gaps of idle cycles go in front, each with a chance of 18 in 100.
   // start is only ever assigned once per time step, so a back-to-back
   // request keeps it high without a glitch.
   task send_request(input logic [ACTION_W-1:0] act,
                     input logic signed [DATA_W-1:0] val,
                     input logic [POSITION_W-1:0] pos);
      while (allow_gaps && $urandom_range(99) < 18) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= pos;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      sb.note_request(act, val, pos);
   endtask

   // Values lean on the extremes now and then, otherwise all 32 bits random.
   function logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return NONE_VALUE;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // Positions: mostly legal for the current fill, with the boundaries and
   // the odd wild value thrown in so the range check gets exercised.
   function logic [POSITION_W-1:0] pick_position(bit for_insert);
      int upper;
      upper = for_insert ? sb.occupancy + 1 : sb.occupancy;
      case ($urandom_range(9))
         0:       return '0;
         1:       return POSITION_W'(upper + 1);
         2:       return POSITION_W'($urandom_range(255));
         3:       return POSITION_W'(upper);
         default: return (upper < 1) ? POSITION_W'(1) : POSITION_W'($urandom_range(upper, 1));
      endcase
   endfunction

   initial begin
      logic [ACTION_W-1:0] act;
      int                  fill_pct;

      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= ACT_INS_FRONT;
      req_value    <= '0;
      req_position <= '0;
      allow_gaps   = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening. Removals on an empty list: the empty check must
      // win over the position check, even with position zero or 255.
      send_request(ACT_REM_FRONT, 32'sd5, 8'd1);
      send_request(ACT_REM_POS,   32'sd5, 8'd0);
      send_request(ACT_REM_POS,   32'sd5, 8'd255);
      send_request(ACT_REM_BACK,  32'sd5, 8'd1);
      // Positional inserts out of range, then legal at one past the end.
      send_request(ACT_INS_POS, 32'sd9, 8'd0);
      send_request(ACT_INS_POS, 32'sd9, 8'd2);
      send_request(ACT_INS_POS, 32'sh7FFF_FFFF, 8'd1);
      send_request(ACT_INS_FRONT, 32'sh8000_0000, 8'd255);
      send_request(ACT_INS_BACK, NONE_VALUE, 8'd0);
      send_request(ACT_INS_POS, 32'sd0, 8'd4);            // append at the back
      send_request(ACT_INS_POS, 32'sh5A5A_A5A5, 8'd2);    // middle insert
      send_request(ACT_INS_POS, 32'sd1, 8'd255);
      // Unused action codes change nothing.
      send_request(ACT_SPARE_LO, 32'sd77, 8'd1);
      send_request(ACT_SPARE_HI, 32'sd77, 8'd1);
      // Removals out of range, then from the middle, back and front.
      send_request(ACT_REM_POS, 32'sd0, 8'd6);
      send_request(ACT_REM_POS, 32'sd0, 8'd0);
      send_request(ACT_REM_POS, 32'sd0, 8'd2);
      send_request(ACT_REM_POS, 32'sd0, 8'd4);            // last entry by position
      send_request(ACT_REM_BACK, 32'sd0, 8'd0);
      send_request(ACT_REM_FRONT, 32'sd0, 8'd0);
      send_request(ACT_REM_FRONT, 32'sd0, 8'd0);          // now empty again

      // Random part in epochs of shifting insert bias, so the fill sweeps
      // between empty and full repeatedly and both error edges get hit,
      // including positional inserts on a full list with a bad position.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         // A long stretch in the middle runs flat out.
         allow_gaps = !(n >= 600 && n < 1000);
         case ((n / 48) % 4)
            0:       fill_pct = 85;
            1:       fill_pct = 20;
            2:       fill_pct = 55;
            default: fill_pct = 70;
         endcase
         if ($urandom_range(99) < 4)
            act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
         else if ($urandom_range(99) < fill_pct)
            act = ACTION_W'($urandom_range(ACT_INS_POS, ACT_INS_FRONT));
         else
            act = ACTION_W'($urandom_range(ACT_REM_POS, ACT_REM_FRONT));
         if (act == ACT_INS_POS)
            send_request(act, pick_value(), pick_position(1'b1));
         else if (act == ACT_REM_POS)
            send_request(act, pick_value(), pick_position(1'b0));
         else
            send_request(act, pick_value(), POSITION_W'($urandom_range(255)));
      end
      start <= 1'b0;

      // Wait for every response, then a few cycles for anything stray.
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/pol_ctrl.sv
rtl/positional_ordered_list.sv
tb/tb_positional_ordered_list.sv
